@@ rtl/stable_priority_wait_list_core_macros.svh @@
// Assertion macros shared by the wait list RTL.
`ifndef STABLE_PRIORITY_WAIT_LIST_CORE_MACROS_SVH
`define STABLE_PRIORITY_WAIT_LIST_CORE_MACROS_SVH
// Implication checked on every edge outside reset.
`define SPWL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SPWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/spwl_pkg.sv @@
// Package with operation and status codes, the sequencer state type and the request, response and entry structs.
`default_nettype none
package spwl_pkg;
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_STAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] room_id;
        logic [7:0]  priority_req;
        logic        waiting;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] hit_room;
        logic [7:0]  hit_priority;
        logic        hit_waiting;
        logic [4:0]  entry_count;
        logic [7:0]  max_priority;
        logic [4:0]  ready_count;
        logic        list_empty;
    } t_rsp;

    typedef struct packed {
        logic [15:0] room;
        logic [7:0]  prio;
        logic        wait_flag;
    } t_entry;
endpackage
`default_nettype wire

@@ rtl/spwl_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface spwl_req_if;
    logic            valid;
    logic            ready;
    spwl_pkg::t_req  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface spwl_rsp_if;
    logic            valid;
    logic            ready;
    spwl_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/spwl_mem.sv @@
// Entry memory with one write port and one registered read port.
`default_nettype none
module spwl_mem #(
    parameter int AW = 4
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [AW-1:0]          i_waddr,
    input  wire spwl_pkg::t_entry i_wdata,
    input  wire [AW-1:0]          i_raddr,
    output spwl_pkg::t_entry      o_rdata
);
    spwl_pkg::t_entry mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/stable_priority_wait_list_core.sv @@
// Top level of the stable priority wait list: sequencer around one entry memory.
// One request at a time; a new one is taken only after the response handshake, once the sequencer is idle.
// Scan and status sweeps read one entry per cycle; the shift alternates a read and a write-back per entry.
// Reset clears the fill count and the sequencer; the memory holds no reset value.
// Only read data from entries below the fill count is ever used.
`default_nettype none
module stable_priority_wait_list_core #(
    parameter int CAPACITY = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    spwl_req_if.sink       i_req,
    spwl_rsp_if.source     o_rsp
);
    `include "stable_priority_wait_list_core_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    spwl_pkg::t_state r_state, n_state;
    spwl_pkg::t_req   r_req, n_req;
    logic [CW-1:0]    r_fill, n_fill;
    // The index walks the list and addresses the next read.
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rv, n_rv;       // read data valid next cycle
    logic [CW-1:0]    r_ridx, n_ridx;   // index of data being returned
    logic             r_hit, n_hit;
    logic [CW-1:0]    r_pos, n_pos;
    spwl_pkg::t_entry r_hent, n_hent;
    logic [7:0]       r_max, n_max;
    logic [CW-1:0]    r_wcnt, n_wcnt;
    logic [1:0]       r_status, n_status;
    spwl_pkg::t_rsp   r_rsp, n_rsp;

    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    spwl_pkg::t_entry w_wdata, w_rdata;

    spwl_mem #(.AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign i_req.ready   = (r_state == spwl_pkg::S_IDLE);
    assign o_rsp.valid   = (r_state == spwl_pkg::S_OUT);
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spwl_pkg::S_IDLE;
            r_fill  <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rv    <= n_rv;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_ridx   <= n_ridx;
        r_hit    <= n_hit;
        r_pos    <= n_pos;
        r_hent   <= n_hent;
        r_max    <= n_max;
        r_wcnt   <= n_wcnt;
        r_status <= n_status;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_rv     = 1'b0;
        n_ridx   = r_idx;
        n_hit    = r_hit;
        n_pos    = r_pos;
        n_hent   = r_hent;
        n_max    = r_max;
        n_wcnt   = r_wcnt;
        n_status = r_status;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = w_rdata;
        w_raddr  = r_idx[AW-1:0];
        unique case (r_state)
            spwl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_req    = i_req.payload;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_hent   = '0;
                    n_max    = '0;
                    n_wcnt   = '0;
                    n_status = spwl_pkg::ST_OK;
                    n_state  = spwl_pkg::S_STAT;
                    unique case (i_req.payload.operation) inside
                        spwl_pkg::OP_PUSH: begin
                            if (r_fill >= CW'(CAPACITY)) begin
                                n_status = spwl_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_fill[AW-1:0];
                                w_wdata = '{room: i_req.payload.room_id,
                                            prio: i_req.payload.priority_req,
                                            wait_flag: i_req.payload.waiting};
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        spwl_pkg::OP_POP: begin
                            if (r_fill == '0) begin
                                n_status = spwl_pkg::ST_EMPTY;
                            end else begin
                                n_state = spwl_pkg::S_SCAN;
                            end
                        end
                        spwl_pkg::OP_REMOVE, spwl_pkg::OP_FIND, spwl_pkg::OP_SET: begin
                            n_state = spwl_pkg::S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            // Scan: pop keeps the earliest entry of highest priority (a later one wins only
            // with a strictly larger priority); lookups keep the earliest matching room.
            spwl_pkg::S_SCAN: begin
                if (r_idx < r_fill) begin
                    n_idx = r_idx + 1'b1;
                    n_rv  = 1'b1;
                end
                if (r_rv) begin
                    if (r_req.operation == spwl_pkg::OP_POP) begin
                        if (!r_hit || w_rdata.prio > r_hent.prio) begin
                            n_hit  = 1'b1;
                            n_pos  = r_ridx;
                            n_hent = w_rdata;
                        end
                    end else if (!r_hit && w_rdata.room == r_req.room_id) begin
                        n_hit  = 1'b1;
                        n_pos  = r_ridx;
                        n_hent = w_rdata;
                    end
                end
                if (r_idx >= r_fill && !r_rv) begin
                    if (!r_hit) begin
                        n_status = spwl_pkg::ST_NOT_FOUND;
                        n_idx    = '0;
                        n_state  = spwl_pkg::S_STAT;
                    end else if (r_req.operation == spwl_pkg::OP_SET) begin
                        w_we     = 1'b1;
                        w_waddr  = r_pos[AW-1:0];
                        w_wdata  = r_hent;
                        w_wdata.wait_flag = r_req.waiting;
                        n_hent.wait_flag  = r_req.waiting;
                        n_idx    = '0;
                        n_state  = spwl_pkg::S_STAT;
                    end else if (r_req.operation == spwl_pkg::OP_FIND) begin
                        n_idx    = '0;
                        n_state  = spwl_pkg::S_STAT;
                    end else begin
                        n_idx    = r_pos + 1'b1;
                        n_state  = spwl_pkg::S_SHIFT;
                    end
                end
            end
            // Shift: read entry k, then write it to k-1, for each entry after the removed one.
            spwl_pkg::S_SHIFT: begin
                if (r_rv) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_ridx - 1'b1);
                    w_wdata = w_rdata;
                end else if (r_idx < r_fill) begin
                    n_rv   = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_idx   = '0;
                    n_state = spwl_pkg::S_STAT;
                end
            end
            // Status sweep: maximum priority and waiting count.
            spwl_pkg::S_STAT: begin
                if (r_idx < r_fill) begin
                    n_idx = r_idx + 1'b1;
                    n_rv  = 1'b1;
                end
                if (r_rv) begin
                    if (w_rdata.prio > r_max) begin
                        n_max = w_rdata.prio;
                    end
                    n_wcnt = r_wcnt + CW'(w_rdata.wait_flag);
                end
                if (r_idx >= r_fill && !r_rv) begin
                    n_rsp.status       = r_status;
                    n_rsp.hit_room     = r_hit ? r_hent.room : '0;
                    n_rsp.hit_priority = r_hit ? r_hent.prio : '0;
                    n_rsp.hit_waiting  = r_hit ? r_hent.wait_flag : 1'b0;
                    n_rsp.entry_count  = 5'(r_fill);
                    n_rsp.max_priority = r_max;
                    n_rsp.ready_count  = 5'(r_wcnt);
                    n_rsp.list_empty   = (r_fill == '0);
                    n_state            = spwl_pkg::S_OUT;
                end
            end
            spwl_pkg::S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = spwl_pkg::S_IDLE;
                end
            end
            default: n_state = spwl_pkg::S_IDLE;
        endcase
    end

    `SPWL_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CW'(CAPACITY))
    `SPWL_ASSERT_IMP(a_empty_cnt, i_clk, i_rst_n, o_rsp.valid,
        o_rsp.payload.list_empty == (o_rsp.payload.entry_count == '0))
    `SPWL_ASSERT_IMP(a_ready_le_cnt, i_clk, i_rst_n, o_rsp.valid,
        o_rsp.payload.ready_count <= o_rsp.payload.entry_count || CAPACITY > 31)
    `SPWL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(o_rsp.payload))
endmodule
`default_nettype wire
